### rtl/decimal_text_to_fixed_point_macros.svh
// ---------------------------------------------------------------------------
// decimal_text_to_fixed_point_macros.svh
// Assertion helpers for the decimal text parser, clocked on clk_i and
// disabled while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH
`define DECIMAL_TEXT_TO_FIXED_POINT_MACROS_SVH

// Same-cycle implication.
`define DTF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DTF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dtf_pkg.sv
// ---------------------------------------------------------------------------
// dtf_pkg
// Shared types, constants and the fraction weight table of the parser.
// ---------------------------------------------------------------------------
`default_nettype none

package dtf_pkg;

  localparam int unsigned FRAC_BITS       = 32;
  localparam int unsigned MAX_FRAC_DIGITS = 9;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned INT_W      = 31;
  localparam int unsigned INT_EXT_W  = INT_W + 4;
  localparam int unsigned FRAC_W     = 32;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned WEIGHT_W   = 29;
  localparam int unsigned PROD_W     = WEIGHT_W + DIGIT_W;
  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned OUT_DATA_W = 72;
  localparam int unsigned IN_DATA_W  = 8;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;

  localparam logic [INT_W-1:0] INT_SAT = {INT_W{1'b1}};

  typedef enum logic [1:0] {
    KIND_DIGIT,
    KIND_MINUS,
    KIND_POINT,
    KIND_OTHER
  } char_kind_e;

  typedef struct packed {
    char_kind_e         kind;
    logic [DIGIT_W-1:0] digit;
    logic               last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // floor(2^32 / 10^(idx+1))
  function automatic logic [WEIGHT_W-1:0] frac_weight(input logic [CNT_W-1:0] idx);
    logic [WEIGHT_W-1:0] w;
    unique case (idx)
      4'd0:    w = 29'd429496729;
      4'd1:    w = 29'd42949672;
      4'd2:    w = 29'd4294967;
      4'd3:    w = 29'd429496;
      4'd4:    w = 29'd42949;
      4'd5:    w = 29'd4294;
      4'd6:    w = 29'd429;
      4'd7:    w = 29'd42;
      4'd8:    w = 29'd4;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/dtf_front.sv
// ---------------------------------------------------------------------------
// dtf_front
// Input side: takes text bytes and sorts each into digit, minus, point or
// other before it enters the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module dtf_front (
  input  wire logic [dtf_pkg::IN_DATA_W-1:0] s_tdata_i,  // [7:0] char_byte
  input  wire logic                          s_tlast_i,  // is_last
  input  wire logic                          s_tvalid_i,
  output logic                               s_tready_o,
  input  wire dtf_pkg::queue_stat_t          q_stat_i,
  output logic                               push_o,
  output dtf_pkg::item_t                     item_o
);

  logic [dtf_pkg::CHAR_W-1:0] ch;
  logic [dtf_pkg::CHAR_W-1:0] ch_off;

  assign ch     = s_tdata_i[dtf_pkg::CHAR_W-1:0];
  assign ch_off = ch - dtf_pkg::CH_ZERO;

  always_comb begin
    item_o.last  = s_tlast_i;
    item_o.digit = ch_off[dtf_pkg::DIGIT_W-1:0];
    priority if (ch >= dtf_pkg::CH_ZERO && ch <= dtf_pkg::CH_NINE) begin
      item_o.kind = dtf_pkg::KIND_DIGIT;
    end else if (ch == dtf_pkg::CH_MINUS) begin
      item_o.kind = dtf_pkg::KIND_MINUS;
    end else if (ch == dtf_pkg::CH_POINT) begin
      item_o.kind = dtf_pkg::KIND_POINT;
    end else begin
      item_o.kind = dtf_pkg::KIND_OTHER;
    end
  end

  assign s_tready_o = !q_stat_i.full;
  assign push_o     = s_tvalid_i && !q_stat_i.full;

endmodule

`default_nettype wire

### rtl/dtf_queue.sv
// ---------------------------------------------------------------------------
// dtf_queue
// Short FIFO of classified bytes between the front and the parser.
// ---------------------------------------------------------------------------
`default_nettype none

module dtf_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire dtf_pkg::item_t item_i,
  input  wire logic           pop_i,
  output dtf_pkg::item_t      item_o,
  output dtf_pkg::queue_stat_t stat_o
);

  dtf_pkg::item_t              mem_q [dtf_pkg::QUEUE_DEPTH];
  logic [dtf_pkg::QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [dtf_pkg::QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [dtf_pkg::QCNT_W-1:0]  count_q, count_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  assign item_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == dtf_pkg::QCNT_W'(dtf_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

### rtl/dtf_back.sv
// ---------------------------------------------------------------------------
// dtf_back
// Parser: walks sign / integer / fraction one byte per cycle (a final byte
// waits for capture), captures the string and forms the signed Q31.32 result.
// ---------------------------------------------------------------------------
`default_nettype none

module dtf_back (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire dtf_pkg::item_t                 item_i,
  input  wire logic                           item_valid_i,
  output logic                                pop_o,
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  // [0] parse_ok, [1] int_overflow, [65:2] fixed_value, [71:66] zero
  output logic [dtf_pkg::OUT_DATA_W-1:0]      m_tdata_o
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_INT   = 2'd1;
  localparam logic [1:0] PH_FRAC  = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  // parser state
  logic [1:0]                  phase_q, phase_d;
  logic                        neg_q, neg_d;
  logic                        seen_q, seen_d;
  logic                        ovf_q, ovf_d;
  logic [dtf_pkg::INT_W-1:0]   int_q, int_d;
  logic [dtf_pkg::FRAC_W-1:0]  frac_q, frac_d;
  logic [dtf_pkg::CNT_W-1:0]   cnt_q, cnt_d;

  // capture stage
  logic                        cap_valid_q;
  logic                        cap_ok_q, cap_ovf_q, cap_neg_q;
  logic [dtf_pkg::INT_W-1:0]   cap_int_q;
  logic [dtf_pkg::FRAC_W-1:0]  cap_frac_q;

  // output register
  logic                        out_valid_q;
  logic [dtf_pkg::OUT_DATA_W-1:0] out_data_q;

  logic                        out_free, cap_free, cap_move, cap_load;
  logic                        int_step;
  logic [dtf_pkg::INT_EXT_W-1:0] int_ext, int_next;
  logic [dtf_pkg::WEIGHT_W-1:0]  weight;
  logic [dtf_pkg::PROD_W-1:0]    frac_prod;
  logic [dtf_pkg::VALUE_W-1:0]   mag, fixed;

  assign out_free = !out_valid_q || m_tready_i;
  assign cap_move = cap_valid_q && out_free;
  assign cap_free = !cap_valid_q || out_free;
  // a non-final byte never needs the capture slot
  assign pop_o    = item_valid_i && (!item_i.last || cap_free);
  assign cap_load = pop_o && item_i.last;

  assign int_ext   = {4'b0, int_q};
  assign int_next  = (int_ext << 3) + (int_ext << 1) + dtf_pkg::INT_EXT_W'(item_i.digit);
  assign weight    = dtf_pkg::frac_weight(cnt_q);
  assign frac_prod = dtf_pkg::PROD_W'(item_i.digit) * dtf_pkg::PROD_W'(weight);

  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    seen_d   = seen_q;
    ovf_d    = ovf_q;
    int_d    = int_q;
    frac_d   = frac_q;
    cnt_d    = cnt_q;
    int_step = 1'b0;

    unique case (phase_q)
      PH_START: begin
        if (item_i.kind == dtf_pkg::KIND_MINUS) begin
          neg_d   = 1'b1;
          phase_d = PH_INT;
        end else begin
          int_step = 1'b1;
        end
      end
      PH_INT: begin
        int_step = 1'b1;
      end
      PH_FRAC: begin
        if (item_i.kind == dtf_pkg::KIND_DIGIT) begin
          if (cnt_q < dtf_pkg::CNT_W'(dtf_pkg::MAX_FRAC_DIGITS)) begin
            frac_d = frac_q + frac_prod[dtf_pkg::FRAC_W-1:0];
            cnt_d  = cnt_q + 1'b1;
          end
        end else begin
          phase_d = PH_DONE;
        end
      end
      PH_DONE: begin
      end
    endcase

    if (int_step) begin
      priority if (item_i.kind == dtf_pkg::KIND_DIGIT) begin
        seen_d  = 1'b1;
        phase_d = PH_INT;
        if (int_next[dtf_pkg::INT_EXT_W-1:dtf_pkg::INT_W] != '0) begin
          int_d = dtf_pkg::INT_SAT;
          ovf_d = 1'b1;
        end else begin
          int_d = int_next[dtf_pkg::INT_W-1:0];
        end
      end else if (item_i.kind == dtf_pkg::KIND_POINT) begin
        phase_d = PH_FRAC;
      end else begin
        phase_d = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      ovf_q   <= 1'b0;
      int_q   <= '0;
      frac_q  <= '0;
      cnt_q   <= '0;
    end else if (pop_o) begin
      if (item_i.last) begin
        phase_q <= PH_START;
        neg_q   <= 1'b0;
        seen_q  <= 1'b0;
        ovf_q   <= 1'b0;
        int_q   <= '0;
        frac_q  <= '0;
        cnt_q   <= '0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        seen_q  <= seen_d;
        ovf_q   <= ovf_d;
        int_q   <= int_d;
        frac_q  <= frac_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cap_load) begin
        cap_valid_q <= 1'b1;
      end else if (cap_move) begin
        cap_valid_q <= 1'b0;
      end
      if (cap_move) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_load) begin
      cap_ok_q   <= seen_d;
      cap_ovf_q  <= ovf_d;
      cap_neg_q  <= neg_d;
      cap_int_q  <= int_d;
      cap_frac_q <= frac_d;
    end
  end

  assign mag = ({{(dtf_pkg::VALUE_W - dtf_pkg::INT_W){1'b0}}, cap_int_q} << dtf_pkg::FRAC_BITS)
             + dtf_pkg::VALUE_W'(cap_frac_q >> (dtf_pkg::FRAC_W - dtf_pkg::FRAC_BITS));

  always_comb begin
    if (!cap_ok_q) begin
      fixed = '0;
    end else if (cap_neg_q) begin
      fixed = '0 - mag;
    end else begin
      fixed = mag;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cap_move) begin
      out_data_q <= {{(dtf_pkg::OUT_DATA_W - dtf_pkg::VALUE_W - 2){1'b0}},
                     fixed, cap_ovf_q, cap_ok_q};
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;

endmodule

`default_nettype wire

### rtl/decimal_text_to_fixed_point.sv
// ---------------------------------------------------------------------------
// decimal_text_to_fixed_point
// Parses ASCII decimal text ([-]ddd[.ddd]) into a signed Q31.32 value.
//
//   channel  direction  payload (low bit first)
//   s_axis   in         tdata: char_byte[7:0]; tlast: is_last
//   m_axis   out        tdata: parse_ok, int_overflow, fixed_value[63:0]
//
// One byte per cycle sustained while the queue has room; the parser
// updates its state once per byte (shift-add times ten, one 4x29 table
// multiply). A final byte travels through the queue, the capture register
// and then the output register with the 64-bit negate.
// Reset clears queue, parser and both result stages; no clearing pass.
// Input stalls only when the 4-entry queue is full; a final byte waits in
// the queue while both result stages are occupied and m_axis_tready is low.
// ---------------------------------------------------------------------------
`default_nettype none

`include "decimal_text_to_fixed_point_macros.svh"

module decimal_text_to_fixed_point (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic [dtf_pkg::IN_DATA_W-1:0] s_axis_tdata,   // [7:0] char_byte
  input  wire logic                          s_axis_tlast,   // is_last
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  // [0] parse_ok, [1] int_overflow, [65:2] fixed_value, [71:66] zero
  output logic [dtf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready
);

  dtf_pkg::item_t       push_item;
  dtf_pkg::item_t       q_item;
  dtf_pkg::queue_stat_t q_stat;
  logic                 q_push;
  logic                 q_pop;

  // result fields, for the checks below
  logic                      res_ok;
  logic                      res_ovf;
  logic [dtf_pkg::VALUE_W:0] res_tail;

  dtf_front u_front (
    .s_tdata_i  (s_axis_tdata),
    .s_tlast_i  (s_axis_tlast),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .q_stat_i   (q_stat),
    .push_o     (q_push),
    .item_o     (push_item)
  );

  dtf_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (push_item),
    .pop_i  (q_pop),
    .item_o (q_item),
    .stat_o (q_stat)
  );

  dtf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (!q_stat.empty),
    .pop_o        (q_pop),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata)
  );

  assign res_ok   = m_axis_tdata[0];
  assign res_ovf  = m_axis_tdata[1];
  assign res_tail = m_axis_tdata[dtf_pkg::VALUE_W+1:1];

  `DTF_ASSERT_NOW(a_pop_not_empty, q_pop, !q_stat.empty, "pop from empty queue")
  `DTF_ASSERT_NOW(a_fail_is_zero, m_axis_tvalid && !res_ok, res_tail == '0, "bad failed parse")
  `DTF_ASSERT_NOW(a_ovf_needs_ok, m_axis_tvalid && res_ovf, res_ok, "overflow without digits")
  `DTF_ASSERT_NEXT(a_full_blocks, q_stat.full && !q_pop, q_stat.full, "queue lost an entry")

endmodule

`default_nettype wire

### test/decimal_text_to_fixed_point_tb.sv
// ----------------------------------------------------------------------------
// decimal_text_to_fixed_point_tb
// Streams ASCII number strings into the parser and checks every Q31.32
// result against a local parser model. A short directed set covers
// minus zero, saturation, dropped fraction digits, a point with no integer
// digits and bytes after a terminator. It is followed by random strings,
// mostly well formed, with random idling on both sides except in a final full-rate phase.
// ----------------------------------------------------------------------------
module decimal_text_to_fixed_point_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SCAN_START,
    SCAN_INT,
    SCAN_FRAC,
    SCAN_DONE
  } scan_state_e;

  // idle profile of the two sides
  typedef enum logic [1:0] {
    MODE_RECV_SLOW,
    MODE_SEND_SLOW,
    MODE_FULL_RATE
  } pace_e;

  typedef struct {
    logic [dtf_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       drain;  // not sent: sender waits until all results are back
    pace_e                      pace;
  } text_req_t;

  typedef struct {
    logic                        ok;
    logic                        ovf;
    logic [dtf_pkg::VALUE_W-1:0] value;
  } fixed_result_t;

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic [dtf_pkg::IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                           s_axis_tlast  = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [dtf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;

  text_req_t     text_q[$];
  fixed_result_t parsed_q[$];
  logic [31:0]   frac_scale [dtf_pkg::MAX_FRAC_DIGITS];

  // parser model state
  scan_state_e                scan_state;
  logic                       sign_neg;
  logic                       have_int;
  logic                       whole_sat;
  logic [dtf_pkg::INT_W-1:0]  whole_acc;
  logic [dtf_pkg::FRAC_W-1:0] frac_acc;
  logic [dtf_pkg::CNT_W-1:0]  frac_digits;

  logic in_taken = 1'b0;
  int   send_idle_pct = 16;
  int   recv_idle_pct = 49;
  int   mismatch_count = 0;
  int   results_seen = 0;
  int   ovf_seen = 0;
  int   invalid_seen = 0;
  int   strings_queued = 0;
  int   bytes_queued = 0;

  decimal_text_to_fixed_point uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic clear_parser();
    scan_state  = SCAN_START;
    sign_neg    = 1'b0;
    have_int    = 1'b0;
    whole_sat   = 1'b0;
    whole_acc   = '0;
    frac_acc    = '0;
    frac_digits = '0;
  endtask

  // one byte into the parser model; a final byte queues the expected value
  task automatic parse_char(input logic [dtf_pkg::CHAR_W-1:0] ch, input logic last);
    logic                        is_num;
    logic [dtf_pkg::DIGIT_W-1:0] d;
    logic [34:0]                 grown;
    logic [dtf_pkg::VALUE_W-1:0] mag;
    fixed_result_t               r;
    is_num = (ch >= dtf_pkg::CH_ZERO) && (ch <= dtf_pkg::CH_NINE);
    d = dtf_pkg::DIGIT_W'(ch - dtf_pkg::CH_ZERO);
    case (scan_state)
      SCAN_START, SCAN_INT: begin
        if (scan_state == SCAN_START && ch == dtf_pkg::CH_MINUS) begin
          sign_neg   = 1'b1;
          scan_state = SCAN_INT;
        end else if (is_num) begin
          grown    = {4'b0, whole_acc} * 35'd10 + 35'(d);
          have_int = 1'b1;
          if (grown > {4'b0, dtf_pkg::INT_SAT}) begin
            whole_acc = dtf_pkg::INT_SAT;
            whole_sat = 1'b1;
          end else begin
            whole_acc = grown[dtf_pkg::INT_W-1:0];
          end
          scan_state = SCAN_INT;
        end else if (ch == dtf_pkg::CH_POINT) begin
          scan_state = SCAN_FRAC;
        end else begin
          scan_state = SCAN_DONE;
        end
      end
      SCAN_FRAC: begin
        if (is_num) begin
          if (frac_digits < dtf_pkg::MAX_FRAC_DIGITS) begin
            frac_acc = frac_acc + 32'(d) * frac_scale[frac_digits];
            frac_digits++;
          end
        end else begin
          scan_state = SCAN_DONE;
        end
      end
      default: ;
    endcase
    if (last) begin
      mag = ({33'b0, whole_acc} << dtf_pkg::FRAC_BITS)
          + 64'(frac_acc >> (32 - dtf_pkg::FRAC_BITS));
      if (!have_int) begin
        mag = '0;
      end else if (sign_neg) begin
        mag = -mag;
      end
      r.ok    = have_int;
      r.ovf   = whole_sat;
      r.value = mag;
      parsed_q.push_back(r);
      clear_parser();
    end
  endtask

  task automatic queue_text(input logic [dtf_pkg::CHAR_W-1:0] txt[$], input pace_e pace);
    text_req_t r;
    foreach (txt[i]) begin
      r.ch    = txt[i];
      r.last  = (i == txt.size() - 1);
      r.drain = 1'b0;
      r.pace  = pace;
      text_q.push_back(r);
    end
    strings_queued++;
    bytes_queued += txt.size();
  endtask

  task automatic queue_str(input string s, input pace_e pace);
    logic [dtf_pkg::CHAR_W-1:0] txt[$];
    for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
    queue_text(txt, pace);
  endtask

  task automatic queue_drain();
    text_req_t r;
    r.ch    = '0;
    r.last  = 1'b0;
    r.drain = 1'b1;
    r.pace  = MODE_FULL_RATE;
    text_q.push_back(r);
  endtask

  // mostly well-formed numbers, some noise and corrupted strings, some tails
  task automatic build_random_text(ref logic [dtf_pkg::CHAR_W-1:0] txt[$],
                                   output int body_len);
    int n;
    int style;
    txt.delete();
    style = $urandom_range(0, 9);
    if (style == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) txt.push_back(dtf_pkg::CHAR_W'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 3) == 0) txt.push_back(dtf_pkg::CH_MINUS);
      if ($urandom_range(0, 7) == 0) n = 0;
      else if ($urandom_range(0, 4) == 0) n = $urandom_range(9, 12);
      else n = $urandom_range(1, 5);
      repeat (n) txt.push_back(dtf_pkg::CH_ZERO + dtf_pkg::CHAR_W'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) != 0) begin
        txt.push_back(dtf_pkg::CH_POINT);
        if ($urandom_range(0, 4) == 0) n = $urandom_range(9, 12);
        else n = $urandom_range(0, 5);
        repeat (n) txt.push_back(dtf_pkg::CH_ZERO + dtf_pkg::CHAR_W'($urandom_range(0, 9)));
      end
      if (style == 1 && txt.size() > 0)
        txt[$urandom_range(0, txt.size() - 1)] = dtf_pkg::CHAR_W'($urandom_range(0, 255));
    end
    if (txt.size() == 0)
      txt.push_back(dtf_pkg::CH_ZERO + dtf_pkg::CHAR_W'($urandom_range(0, 9)));
    body_len = txt.size();
    // random tail bytes after the string proper; the parser reads them like any other byte
    if ($urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) txt.push_back(dtf_pkg::CHAR_W'($urandom_range(0, 255)));
    end
  endtask

  // sender and receiver
  always @(negedge clk_i) begin
    logic keep;
    logic load;
    if (rst_ni) begin
      keep = s_axis_tvalid && !in_taken;
      load = 1'b0;
      if (!keep && text_q.size() > 0) begin
        if (text_q[0].drain) begin
          if (parsed_q.size() == 0) void'(text_q.pop_front());
        end else if ($urandom_range(0, 99) >= send_idle_pct) begin
          load = 1'b1;
        end
      end
      if (load) begin
        s_axis_tdata <= text_q[0].ch;
        s_axis_tlast <= text_q[0].last;
        case (text_q[0].pace)
          MODE_RECV_SLOW: begin
            send_idle_pct = 16;
            recv_idle_pct = 49;
          end
          MODE_SEND_SLOW: begin
            send_idle_pct = 49;
            recv_idle_pct = 16;
          end
          default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
          end
        endcase
        void'(text_q.pop_front());
      end
      s_axis_tvalid <= keep || load;
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // accepted bytes feed the model, accepted results are checked
  always @(posedge clk_i) begin
    fixed_result_t want;
    in_taken = s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (in_taken) parse_char(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (parsed_q.size() == 0) begin
          report_mismatch($sformatf("result with no request pending, tdata %h", m_axis_tdata));
        end else begin
          want = parsed_q.pop_front();
          if (want.ovf) ovf_seen++;
          if (!want.ok) invalid_seen++;
          if (m_axis_tdata[0] !== want.ok)
            report_mismatch($sformatf("result %0d parse_ok %b, expected %b",
                                      results_seen, m_axis_tdata[0], want.ok));
          if (m_axis_tdata[1] !== want.ovf)
            report_mismatch($sformatf("result %0d int_overflow %b, expected %b",
                                      results_seen, m_axis_tdata[1], want.ovf));
          if (m_axis_tdata[dtf_pkg::VALUE_W+1:2] !== want.value)
            report_mismatch($sformatf("result %0d fixed_value %h, expected %h",
                                      results_seen, m_axis_tdata[dtf_pkg::VALUE_W+1:2],
                                      want.value));
        end
      end
    end
  end

  initial begin
    logic [dtf_pkg::CHAR_W-1:0] txt[$];
    longint unsigned            pow10;
    int                         body_len;
    int                         random_bytes;
    pace_e                      pace;
    pace_e                      next_pace;

    pow10 = 10;
    for (int k = 0; k < dtf_pkg::MAX_FRAC_DIGITS; k++) begin
      frac_scale[k] = 32'((64'd1 << 32) / pow10);
      pow10 *= 10;
    end
    clear_parser();

    pace = MODE_RECV_SLOW;
    queue_str("-0", pace);
    queue_str("-.5", pace);
    txt = {8'h00};
    queue_text(txt, pace);
    queue_str("2147483648", pace);
    queue_str("7.0123456789", pace);
    queue_str("3z-.9", pace);
    txt = {8'hFF, dtf_pkg::CH_NINE};
    queue_text(txt, pace);
    queue_drain();

    random_bytes = 0;
    while (random_bytes < 500) begin
      if (random_bytes >= 333) next_pace = MODE_FULL_RATE;
      else if (random_bytes >= 167) next_pace = MODE_SEND_SLOW;
      else next_pace = MODE_RECV_SLOW;
      if (next_pace != pace) begin
        queue_drain();
        pace = next_pace;
      end
      build_random_text(txt, body_len);
      random_bytes += body_len;
      queue_text(txt, pace);
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (parsed_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("run: %0d strings, %0d bytes, %0d results checked", strings_queued,
             bytes_queued, results_seen);
    $display("run: %0d saturated integers, %0d strings without integer digits",
             ovf_seen, invalid_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results still pending", parsed_q.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
